>>> rtl/cbb_pkg.sv
`default_nettype none

package cbb_pkg;

  // Width of the used and free counts on the result side.
  localparam int unsigned CountW = 10;

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SKIP   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_STATUS = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_e;

  typedef struct packed {
    op_e        opcode;
    logic [6:0] length;
    logic [7:0] data_byte;
    logic       first_of_burst;
    logic       last_of_burst;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        out_byte;
    logic              last_result;
    logic [CountW-1:0] used_count;
    logic [CountW-1:0] free_count;
  } rsp_t;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_STREAM
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic exec;  // execute the item on the request port this cycle
    logic step;  // read and emit one byte of a dequeue or peek
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stream_start;  // request on the port would start a byte stream
    logic stream_last;   // the next step emits the final byte
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/cbb_ram.sv
`default_nettype none

module cbb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/cbb_dp.sv
`default_nettype none

module cbb_dp #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbb_pkg::cmd_t cmd_i,
  output cbb_pkg::sts_t      sts_o,
  input  wire cbb_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output cbb_pkg::rsp_t      rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0] DepthX = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] DepthM1 = AW'(DEPTH - 1);
  localparam logic [AW-1:0] OneA = AW'(1);
  localparam logic [6:0] MaxBurst = 7'(MAX_BURST);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [AW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= DepthX) begin
      s = s - DepthX;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d, swp_q, swp_d;
  logic          brej_q, brej_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic [6:0]    rem_q, rem_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          rsp_stream_q, rsp_stream_d;
  logic          rsp_last_q, rsp_last_d;
  cbb_pkg::status_e rsp_status_q, rsp_status_d;

  logic [AW:0]    diff;
  logic [AW-1:0]  used, free;
  logic [AW+6:0]  len_x, used_x, free_x;
  logic           len_zero, too_much_data, stream_ok;
  logic [AW-1:0]  skip_n;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [7:0]     rdata;
  logic           br_v;
  logic [AW-1:0]  sp_v;
  cbb_pkg::status_e st_v;
  logic [AW+9:0]  used_w, free_w;

  // Occupancy from the committed pointers.
  always_comb begin
    diff = {1'b0, wp_q} - {1'b0, rp_q};
    if (wp_q < rp_q) begin
      diff = diff + DepthX;
    end
    used = diff[AW-1:0];
    free = DepthM1 - used;
  end

  assign len_x         = {{AW{1'b0}}, req_i.length};
  assign used_x        = {7'b0, used};
  assign free_x        = {7'b0, free};
  assign len_zero      = (req_i.length == 7'd0);
  assign too_much_data = (req_i.length > MaxBurst) || (len_x > used_x);
  assign skip_n        = (len_x < used_x) ? AW'(req_i.length) : used;
  assign stream_ok     = ((req_i.opcode == cbb_pkg::OP_DEQ) ||
                          (req_i.opcode == cbb_pkg::OP_PEEK)) &&
                         !len_zero && !too_much_data;

  assign sts_o.stream_start = stream_ok;
  assign sts_o.stream_last  = (rem_q == 7'd1);

  always_comb begin
    rp_d         = rp_q;
    wp_d         = wp_q;
    swp_d        = swp_q;
    brej_d       = brej_q;
    raddr_d      = raddr_q;
    rem_d        = rem_q;
    rsp_valid_d  = 1'b0;
    rsp_stream_d = 1'b0;
    rsp_last_d   = 1'b0;
    rsp_status_d = cbb_pkg::ST_OK;
    we           = 1'b0;
    waddr        = swp_q;
    br_v         = brej_q;
    sp_v         = swp_q;
    st_v         = cbb_pkg::ST_OK;
    if (cmd_i.exec) begin
      rsp_valid_d = 1'b1;
      rsp_last_d  = 1'b1;
      unique case (req_i.opcode)
        cbb_pkg::OP_ENQ: begin
          // Opening byte checks room for the whole burst up front.
          if (req_i.first_of_burst) begin
            if (len_zero) begin
              st_v = cbb_pkg::ST_ZERO_LEN;
              br_v = 1'b1;
            end else if ((req_i.length > MaxBurst) || (len_x > free_x)) begin
              st_v = cbb_pkg::ST_NO_SPACE;
              br_v = 1'b1;
            end else begin
              br_v = 1'b0;
            end
            sp_v = wp_q;
          end
          if (st_v == cbb_pkg::ST_OK) begin
            if (br_v) begin
              st_v = cbb_pkg::ST_NO_SPACE;
            end else if (wrap_add(sp_v, OneA) == rp_q) begin
              st_v = cbb_pkg::ST_NO_SPACE;
              br_v = 1'b1;
            end else begin
              we    = 1'b1;
              waddr = sp_v;
              sp_v  = wrap_add(sp_v, OneA);
            end
          end
          if (req_i.last_of_burst) begin
            if (!br_v) begin
              wp_d = sp_v;
              sp_v = sp_v;
            end else begin
              sp_v = wp_q;
            end
            br_v = 1'b0;
          end
          brej_d       = br_v;
          swp_d        = sp_v;
          rsp_status_d = st_v;
        end
        cbb_pkg::OP_DEQ, cbb_pkg::OP_PEEK: begin
          if (len_zero) begin
            rsp_status_d = cbb_pkg::ST_ZERO_LEN;
          end else if (too_much_data) begin
            rsp_status_d = cbb_pkg::ST_NO_DATA;
          end else begin
            // Bytes follow one per cycle from the stream steps.
            rsp_valid_d = 1'b0;
            raddr_d     = rp_q;
            rem_d       = req_i.length;
            if (req_i.opcode == cbb_pkg::OP_DEQ) begin
              rp_d = wrap_add(rp_q, AW'(req_i.length));
            end
          end
        end
        cbb_pkg::OP_SKIP: begin
          if (len_zero) begin
            rsp_status_d = cbb_pkg::ST_ZERO_LEN;
          end else begin
            rp_d = wrap_add(rp_q, skip_n);
          end
        end
        cbb_pkg::OP_CLEAR: begin
          rp_d   = '0;
          wp_d   = '0;
          swp_d  = '0;
          brej_d = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.step) begin
      rsp_valid_d  = 1'b1;
      rsp_stream_d = 1'b1;
      rsp_last_d   = (rem_q == 7'd1);
      raddr_d      = wrap_add(raddr_q, OneA);
      rem_d        = rem_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q         <= '0;
      wp_q         <= '0;
      swp_q        <= '0;
      brej_q       <= 1'b0;
      raddr_q      <= '0;
      rem_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_stream_q <= 1'b0;
      rsp_last_q   <= 1'b0;
      rsp_status_q <= cbb_pkg::ST_OK;
    end else begin
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      swp_q        <= swp_d;
      brej_q       <= brej_d;
      raddr_q      <= raddr_d;
      rem_q        <= rem_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_stream_q <= rsp_stream_d;
      rsp_last_q   <= rsp_last_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  cbb_ram #(
    .Width (8),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.data_byte),
    .re_i    (cmd_i.step),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  // Counts reflect the pointers after the item; they only move on the next accept.
  assign used_w = {10'b0, used};
  assign free_w = {10'b0, free};

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.out_byte    = rsp_stream_q ? rdata : 8'd0;
  assign rsp_o.last_result = rsp_last_q;
  assign rsp_o.used_count  = used_w[cbb_pkg::CountW-1:0];
  assign rsp_o.free_count  = free_w[cbb_pkg::CountW-1:0];

endmodule

`default_nettype wire

>>> rtl/cbb_ctrl.sv
`default_nettype none

module cbb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cbb_pkg::sts_t sts_i,
  output cbb_pkg::cmd_t      cmd_o,
  output logic               busy_o
);

  cbb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbb_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.step = 1'b0;
    busy_o     = 1'b0;
    unique case (state_q)
      cbb_pkg::CTRL_IDLE: begin
        cmd_o.exec = start_i;
        if (start_i && sts_i.stream_start) begin
          state_d = cbb_pkg::CTRL_STREAM;
        end
      end
      cbb_pkg::CTRL_STREAM: begin
        busy_o     = 1'b1;
        cmd_o.step = 1'b1;
        if (sts_i.stream_last) begin
          state_d = cbb_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = cbb_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/circular_byte_buffer.sv
`default_nettype none

// Circular byte FIFO with DEPTH slots that holds up to DEPTH-1 bytes.
// An item is presented on req_i and is accepted at a rising edge where start_i
// is high and busy_o is low. Each result appears on rsp_o for exactly one cycle,
// marked by rsp_valid_o; the receiver cannot stall, so results are never held.
// Enqueue, skip, clear, status and refused requests give a single result in the
// cycle after acceptance, and busy_o stays low, so such items can be issued every
// cycle. An accepted dequeue or peek of N bytes raises busy_o while
// the controller reads one byte per cycle from the synchronous byte memory; the
// bytes appear in order after acceptance, each from a registered memory read,
// the last one marked by last_result. A new item can be accepted in the cycle
// the final byte is shown. Each byte takes one read on the single read port.
// Enqueue bursts are staged and become visible only when their last byte commits.
// Reset empties the buffer and drops any open burst; the byte memory itself is
// not cleared, and no byte that was never written is ever read.

module circular_byte_buffer #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire cbb_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output cbb_pkg::rsp_t      rsp_o
);

  // Commands and status between the controller and the datapath.
  cbb_pkg::cmd_t cmd;
  cbb_pkg::sts_t sts;

  cbb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // The datapath holds the pointers, the byte memory and the result register.
  cbb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_circular_byte_buffer.sv
`timescale 1ns / 1ps

module tb_circular_byte_buffer;
  import cbb_pkg::*;

  localparam int SLOTS = 1024;
  localparam int CAP = SLOTS - 1;
  localparam int MAX_LEN = 64;
  localparam int RAND_ITEMS = 330;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  // Opcodes that the package leaves unnamed; the block treats them like status.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  // Side channel from the driver: a hand-written result for the item on req_i.
  bit   typed_chk;
  rsp_t typed_rsp;

  // Shadow of the buffer, updated on every accepted item.
  logic [7:0] byte_mem [SLOTS];
  logic [9:0] rd_ptr, wr_ptr, stg_ptr;
  bit         rejected;

  rsp_t predicted_rsp [$];
  int   mismatch_cnt;
  int   idle_cycles;
  int   items_sent;
  bit   gaps_on;

  dir_row_t dir_table [$];

  circular_byte_buffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [9:0] fifo_used();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic void push_rsp(status_e st, logic [7:0] b, bit fin);
    rsp_t r;
    r.status      = st;
    r.out_byte    = b;
    r.last_result = fin;
    r.used_count  = fifo_used();
    r.free_count  = 10'(CAP) - fifo_used();
    predicted_rsp.push_back(r);
  endfunction

  // Works out the results of one accepted item and advances the shadow state.
  function automatic void buffer_apply(req_t r);
    status_e     st;
    int unsigned len;
    int unsigned n;
    logic [9:0]  base;
    st  = ST_OK;
    len = r.length;
    case (r.opcode)
      OP_ENQ: begin
        if (r.first_of_burst) begin
          if (len == 0) begin
            st = ST_ZERO_LEN;
            rejected = 1'b1;
          end else if (len > MAX_LEN || len > CAP - fifo_used()) begin
            st = ST_NO_SPACE;
            rejected = 1'b1;
          end else begin
            rejected = 1'b0;
          end
          stg_ptr = wr_ptr;
        end
        if (st == ST_OK) begin
          if (rejected) begin
            st = ST_NO_SPACE;
          end else if (stg_ptr + 10'd1 == rd_ptr) begin
            // The burst ran past its declared size into a full buffer.
            st = ST_NO_SPACE;
            rejected = 1'b1;
          end else begin
            byte_mem[stg_ptr] = r.data_byte;
            stg_ptr = stg_ptr + 10'd1;
          end
        end
        if (r.last_of_burst) begin
          if (!rejected) begin
            wr_ptr = stg_ptr;
          end
          rejected = 1'b0;
          stg_ptr  = wr_ptr;
        end
        push_rsp(st, 8'h00, 1'b1);
      end
      OP_DEQ, OP_PEEK: begin
        if (len == 0) begin
          push_rsp(ST_ZERO_LEN, 8'h00, 1'b1);
        end else if (len > MAX_LEN || len > fifo_used()) begin
          push_rsp(ST_NO_DATA, 8'h00, 1'b1);
        end else begin
          base = rd_ptr;
          if (r.opcode == OP_DEQ) rd_ptr = rd_ptr + 10'(len);
          for (int k = 0; k < len; k++) begin
            push_rsp(ST_OK, byte_mem[base + 10'(k)], k == len - 1);
          end
        end
      end
      OP_SKIP: begin
        if (len == 0) begin
          st = ST_ZERO_LEN;
        end else begin
          n = (len < fifo_used()) ? len : fifo_used();
          rd_ptr = rd_ptr + 10'(n);
        end
        push_rsp(st, 8'h00, 1'b1);
      end
      OP_CLEAR: begin
        rd_ptr   = '0;
        wr_ptr   = '0;
        stg_ptr  = '0;
        rejected = 1'b0;
        push_rsp(ST_OK, 8'h00, 1'b1);
      end
      default: push_rsp(ST_OK, 8'h00, 1'b1);
    endcase
  endfunction

  function automatic req_t mk_req(op_e op, int len, logic [7:0] data, bit f, bit l);
    req_t r;
    r.opcode         = op;
    r.length         = 7'(len);
    r.data_byte      = data;
    r.first_of_burst = f;
    r.last_of_burst  = l;
    return r;
  endfunction

  // One directed row. With typed set, the single result is given by hand:
  // out_byte 0, last set, and free equal to the capacity less the used count.
  function automatic dir_row_t row(op_e op, int len, logic [7:0] data, bit f, bit l,
                                   bit typed, status_e st, int used);
    dir_row_t d;
    d.req                 = mk_req(op, len, data, f, l);
    d.typed               = typed;
    d.rsp.status          = st;
    d.rsp.out_byte        = 8'h00;
    d.rsp.last_result     = 1'b1;
    d.rsp.used_count      = 10'(used);
    d.rsp.free_count      = 10'(CAP - used);
    return d;
  endfunction

  // Presents one item after a random gap and returns once it has been taken.
  task automatic send_item(req_t r, bit typed, rsp_t want);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    req_i     <= r;
    typed_chk <= typed;
    typed_rsp <= want;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Sends n_bytes enqueue items; with with_first set, the first is a header announcing len bytes.
  task automatic send_burst(int len, int n_bytes, bit with_first, bit with_last);
    bit f;
    bit l;
    for (int i = 0; i < n_bytes; i++) begin
      f = with_first && (i == 0);
      l = with_last && (i == n_bytes - 1);
      send_item(mk_req(OP_ENQ, f ? len : $urandom_range(0, 127), 8'($urandom), f, l),
                1'b0, '0);
    end
  endtask

  task automatic send_stream_req();
    op_e op;
    int  len;
    int  top;
    op  = $urandom_range(0, 1) ? OP_DEQ : OP_PEEK;
    top = (fifo_used() > MAX_LEN) ? MAX_LEN : int'(fifo_used());
    if (top > 0 && $urandom_range(0, 4) != 0) len = $urandom_range(1, top);
    else len = $urandom_range(0, 127);
    send_item(mk_req(op, len, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1)),
              1'b0, '0);
  endtask

  // Result checking, acceptance tracking and the watchdog, all on the clock edge.
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    bit   busy_edge;
    if (rst_ni) begin
      busy_edge = 1'b0;
      if (rsp_valid_o) begin
        busy_edge = 1'b1;
        if (predicted_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, status %0d byte %h", $realtime,
                     rsp_o.status, rsp_o.out_byte);
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp_o.status !== want.status || rsp_o.out_byte !== want.out_byte ||
              rsp_o.last_result !== want.last_result ||
              rsp_o.used_count !== want.used_count ||
              rsp_o.free_count !== want.free_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: mismatch exp/got status %0d/%0d byte %h/%h last %b/%b",
                       $realtime, want.status, rsp_o.status, want.out_byte,
                       rsp_o.out_byte, want.last_result, rsp_o.last_result,
                       " used %0d/%0d free %0d/%0d", want.used_count,
                       rsp_o.used_count, want.free_count, rsp_o.free_count);
          end
        end
      end
      if (start_i && !busy_o) begin
        busy_edge = 1'b1;
        buffer_apply(req_i);
        if (typed_chk) begin
          // Hand-written rows give one result; it replaces the predicted one.
          void'(predicted_rsp.pop_back());
          predicted_rsp.push_back(typed_rsp);
        end
      end
      idle_cycles = busy_edge ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int len;
    int rand_start;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    req_i        <= '0;
    typed_chk    <= 1'b0;
    typed_rsp    <= '0;
    rd_ptr       = '0;
    wr_ptr       = '0;
    stg_ptr      = '0;
    rejected     = 1'b0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    items_sent   = 0;
    gaps_on      = 1'b1;

    dir_table = '{
      row(OP_STATUS, 0, 8'h00, 0, 0, 1, ST_OK, 0),
      row(OP_DEQ, 1, 8'h00, 0, 0, 1, ST_NO_DATA, 0),
      row(OP_PEEK, 0, 8'h00, 0, 0, 1, ST_ZERO_LEN, 0),
      row(OP_SKIP, 0, 8'h00, 0, 0, 1, ST_ZERO_LEN, 0),
      // Zero-length header rejects the burst; the stray closing byte is dropped.
      row(OP_ENQ, 0, 8'h00, 1, 0, 1, ST_ZERO_LEN, 0),
      row(OP_ENQ, 0, 8'hFF, 0, 1, 1, ST_NO_SPACE, 0),
      row(OP_ENQ, 65, 8'h00, 1, 0, 1, ST_NO_SPACE, 0),
      row(OP_ENQ, 127, 8'hFF, 1, 1, 1, ST_NO_SPACE, 0),
      // A three-byte burst only shows up once its last byte commits.
      row(OP_ENQ, 3, 8'h00, 1, 0, 1, ST_OK, 0),
      row(OP_ENQ, 0, 8'hFF, 0, 0, 1, ST_OK, 0),
      row(OP_ENQ, 0, 8'hA5, 0, 1, 1, ST_OK, 3),
      row(OP_PEEK, 3, 8'h00, 0, 0, 0, ST_OK, 0),
      row(OP_DEQ, 4, 8'h00, 0, 0, 1, ST_NO_DATA, 3),
      row(OP_PEEK, 65, 8'h00, 0, 0, 1, ST_NO_DATA, 3),
      row(OP_DEQ, 2, 8'h00, 0, 0, 0, ST_OK, 0),
      // Skip is bounded by what is held.
      row(OP_SKIP, 127, 8'h00, 0, 0, 1, ST_OK, 0),
      // A byte with no header is staged like a normal burst byte.
      row(OP_ENQ, 0, 8'h5A, 0, 1, 1, ST_OK, 1),
      row(OP_ENQ, 1, 8'h3C, 1, 1, 1, ST_OK, 2),
      row(op_e'(OP_SPARE_LO), 0, 8'h00, 0, 0, 1, ST_OK, 2),
      row(op_e'(OP_SPARE_HI), 127, 8'hFF, 1, 1, 1, ST_OK, 2),
      // Clear abandons the open burst.
      row(OP_ENQ, 5, 8'h11, 1, 0, 1, ST_OK, 2),
      row(OP_CLEAR, 0, 8'h00, 0, 0, 1, ST_OK, 0),
      row(OP_ENQ, 64, 8'h80, 1, 1, 1, ST_OK, 1),
      row(OP_DEQ, 1, 8'h00, 0, 0, 0, ST_OK, 0),
      row(OP_SKIP, 1, 8'h00, 0, 0, 1, ST_OK, 0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_item(dir_table[i].req, dir_table[i].typed, dir_table[i].rsp);

    // Random rounds until the item budget is spent.
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, MAX_LEN);
          send_burst(len, len, 1'b1, 1'b1);
        end
        4: begin
          len = $urandom_range(1, MAX_LEN);
          case ($urandom_range(0, 4))
            0: send_burst(len, len + $urandom_range(1, 8), 1'b1, 1'b1);
            1: send_burst(len, $urandom_range(1, len), 1'b1, 1'b1);
            2: send_burst(len, len, 1'b1, 1'b0);
            3: send_burst(len, len, 1'b0, 1'b1);
            default: send_burst($urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                                $urandom_range(1, 4), 1'b1, 1'b1);
          endcase
        end
        5, 6, 7: send_stream_req();
        8: begin
          case ($urandom_range(0, 7))
            0, 1, 2: send_item(mk_req(OP_SKIP, $urandom_range(0, 127), 8'($urandom),
                                      0, 0), 1'b0, '0);
            3: send_item(mk_req(OP_CLEAR, $urandom_range(0, 127), 8'($urandom), 0, 0),
                         1'b0, '0);
            4, 5: send_item(mk_req(OP_STATUS, $urandom_range(0, 127), 8'($urandom),
                                   0, 0), 1'b0, '0);
            6: send_item(mk_req(op_e'(OP_SPARE_LO), 0, 8'($urandom), 0, 0), 1'b0, '0);
            default: send_item(mk_req(op_e'(OP_SPARE_HI), 0, 8'($urandom), 1, 1),
                               1'b0, '0);
          endcase
        end
        default: begin
          // Noise: any opcode with any flags and lengths.
          send_item(mk_req(op_e'(3'($urandom_range(0, 7))), $urandom_range(0, 127),
                           8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1)),
                    1'b0, '0);
        end
      endcase
    end

    start_i <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatch_cnt += predicted_rsp.size();

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
